// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the first expression holds, the second must hold in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/ptsdl_pkg.sv
package ptsdl_pkg;

  // Fixed widths of the time base and of the charged airtime.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned AIR_W  = 16;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned PERM_W = 10;
  localparam int unsigned CEIL_W = TIME_W + PERM_W;

  // Survival beacon settings and the permille divisor.
  localparam logic [TIME_W-1:0] SURV_PERIOD  = 32'd20000;
  localparam logic [AIR_W-1:0]  SURV_AIRTIME = 16'd1712;
  localparam logic [PERM_W-1:0] PERMILLE_DIV = 10'd1000;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_PERMILLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AIRTIME      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP      = 3'd5;

  // One airtime record held by a ring cell.
  typedef struct packed {
    logic [TIME_W-1:0] send_time;
    logic [AIR_W-1:0]  airtime;
  } entry_t;

  // Operation applied to every cell of the chain in the same cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SHIFT  = 2'd1,
    OP_ROTATE = 2'd2,
    OP_CHARGE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   wr;
  } cell_ctrl_t;

  // Wrap-safe time compare: now has reached the deadline.
  function automatic logic reached(logic [TIME_W-1:0] now, logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = now - deadline;
    return ~diff[TIME_W-1];
  endfunction

endpackage

// File: sv/ptsdl_if.sv
// Request channel: one scheduler tick.
interface ptsdl_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_time;
  logic        bus_held;
  logic [31:0] packet_tag;

  modport source (output valid, now_time, bus_held, packet_tag, input ready);
  modport sink   (input valid, now_time, bus_held, packet_tag, output ready);
endinterface

// Response channel: the outcome of one tick.
interface ptsdl_rsp_if;
  logic        valid;
  logic        ready;
  logic        send_now;
  logic [31:0] sent_tag;
  logic [15:0] sent_sequence;

  modport source (output valid, send_now, sent_tag, sent_sequence, input ready);
  modport sink   (input valid, send_now, sent_tag, sent_sequence, output ready);
endinterface

// File: sv/ptsdl_cell.sv
module ptsdl_cell import ptsdl_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  entry_t           next_i,
  input  entry_t           head_i,
  output entry_t           entry_o
);

  localparam logic [CNT_W-1:0] POS  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(IDX + 1);

  entry_t entry_q, entry_d;

  // Shift toward the head, close the occupied loop on rotate, or take a new record at the tail.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_SHIFT: begin
        entry_d = next_i;
      end
      OP_ROTATE: begin
        entry_d = (count_i == LAST) ? head_i : next_i;
      end
      OP_CHARGE: begin
        if (count_i == POS) begin
          entry_d = ctrl_i.wr;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: sv/ptsdl_ring.sv
module ptsdl_ring import ptsdl_pkg::*; #(
  parameter int unsigned N     = 16,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  output entry_t           head_o,
  output logic [CNT_W-1:0] count_o,
  output logic             full_o
);

`include "assert_macros.svh"

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(N);

  logic [CNT_W-1:0] count_q, count_d;
  entry_t           ent [N];
  entry_t           nxt [N];

  // Occupancy: the head cell leaves on shift, a record joins on charge.
  always_comb begin
    count_d = count_q;
    case (ctrl_i.op)
      OP_SHIFT:  count_d = count_q - 1'b1;
      OP_CHARGE: count_d = count_q + 1'b1;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The chain itself: each cell hands its record to the cell in front of it.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      assign nxt[i] = ent[i];
    end else begin : g_body
      assign nxt[i] = ent[i+1];
    end

    ptsdl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .count_i (count_q),
      .next_i  (nxt[i]),
      .head_i  (ent[0]),
      .entry_o (ent[i])
    );
  end

  assign head_o  = ent[0];
  assign count_o = count_q;
  assign full_o  = (count_q == FULL_CNT);

  `ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "ring occupancy above capacity")
  `ASSERT_ALWAYS(a_no_charge_full, (ctrl_i.op == OP_CHARGE) |-> !full_o, "charge into a full ring")
  `ASSERT_ALWAYS(a_no_shift_empty, (ctrl_i.op == OP_SHIFT) |-> (count_q != '0), "expiry on an empty ring")

endmodule

// File: sv/periodic_tx_scheduler_duty_limit.sv
// Flow: a request passes EVAL and GATE, then goes to FIN when no send is tried; else DROP
// expires old records and goes to FIN if the ring is still full, or SUM walks the ring cells,
// SCALE and CHECK test the duty limit, and FIN loads the response register. A new request is
// taken only in IDLE, after the last result has been loaded into the response register.
// Reset: asynchronous, active low; control and configuration registers take their default values, the ring is empty.
module periodic_tx_scheduler_duty_limit import ptsdl_pkg::*; #(
  parameter int unsigned RING_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_W-1:0]    cfg_data_i,
  ptsdl_req_if.sink            req_i,
  ptsdl_rsp_if.source          rsp_o
);

`include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(RING_ENTRIES + 1);
  localparam int unsigned SUM_W = AIR_W + CNT_W;
  localparam int unsigned LHS_W = SUM_W + PERM_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EVAL  = 8'b0000_0010,
    ST_GATE  = 8'b0000_0100,
    ST_DROP  = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_SCALE = 8'b0010_0000,
    ST_CHECK = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic              beacon_q;
  logic [TIME_W-1:0] period_q, window_q, gap_q;
  logic [PERM_W-1:0] permille_q;
  logic [AIR_W-1:0]  airtime_q;

  // Scheduler state.
  logic              epoch_q, epoch_d;
  logic [TIME_W-1:0] next_cycle_q, next_cycle_d;
  logic [SEQ_W-1:0]  seq_cnt_q, seq_cnt_d;
  logic [TIME_W-1:0] slot_tag_q, slot_tag_d;
  logic [SEQ_W-1:0]  slot_seq_q, slot_seq_d;
  logic [TIME_W-1:0] slot_due_q, slot_due_d;
  logic              slot_pend_q, slot_pend_d;
  logic              ever_sent_q, ever_sent_d;
  logic [TIME_W-1:0] last_send_q, last_send_d;

  // Current request and walk registers.
  logic [TIME_W-1:0] now_q, tag_q;
  logic              busy_q;
  logic [CNT_W-1:0]  step_q, step_d;
  logic [SUM_W-1:0]  used_q, used_d;
  logic [LHS_W-1:0]  lhs_q, lhs_d;
  logic [CEIL_W-1:0] ceil_q;
  logic              send_q, send_d;

  // Output register.
  logic              out_valid_q, out_valid_d, out_load;
  logic              out_send_q;
  logic [TIME_W-1:0] out_tag_q;
  logic [SEQ_W-1:0]  out_seq_q;

  // Ring interface.
  cell_ctrl_t        ring_ctrl;
  entry_t            head;
  logic [CNT_W-1:0]  ring_count;
  logic              ring_full;

  // Derived values.
  logic [TIME_W-1:0] act_period, nct, cyc_start;
  logic [AIR_W-1:0]  act_air;
  logic              cycle_due, cycle_late, gap_short, head_expired, req_acc;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beacon_q   <= 1'b0;
      period_q   <= 32'd1000;
      window_q   <= 32'd60000;
      permille_q <= 10'd100;
      airtime_q  <= 16'd100;
      gap_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BEACON_MODE:   beacon_q   <= cfg_data_i[0];
        CFG_CYCLE_PERIOD:  period_q   <= cfg_data_i;
        CFG_DUTY_WINDOW:   window_q   <= cfg_data_i;
        CFG_DUTY_PERMILLE: permille_q <= cfg_data_i[PERM_W-1:0];
        CFG_AIRTIME:       airtime_q  <= cfg_data_i[AIR_W-1:0];
        CFG_MIN_GAP:       gap_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Window times permille; users keep the configuration steady while a request is in work (not enforced).
  always_ff @(posedge clk_i) begin
    ceil_q <= CEIL_W'(window_q) * CEIL_W'(permille_q);
  end

  assign act_period = beacon_q ? SURV_PERIOD : period_q;
  assign act_air    = beacon_q ? SURV_AIRTIME : airtime_q;

  // Cycle timing: anchor on the first tick and re-anchor when a full period late.
  assign nct        = epoch_q ? next_cycle_q : now_q;
  assign cycle_due  = reached(now_q, nct);
  assign cycle_late = reached(now_q, nct + act_period);
  assign cyc_start  = cycle_late ? now_q : nct;

  assign gap_short    = ever_sent_q && !reached(now_q, last_send_q + gap_q);
  assign head_expired = (ring_count != '0) && reached(now_q, head.send_time + window_q);

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);

  // Sequencer for one tick.
  always_comb begin
    state_d      = state_q;
    epoch_d      = epoch_q;
    next_cycle_d = next_cycle_q;
    seq_cnt_d    = seq_cnt_q;
    slot_tag_d   = slot_tag_q;
    slot_seq_d   = slot_seq_q;
    slot_due_d   = slot_due_q;
    slot_pend_d  = slot_pend_q;
    ever_sent_d  = ever_sent_q;
    last_send_d  = last_send_q;
    step_d       = step_q;
    used_d       = used_q;
    lhs_d        = lhs_q;
    send_d       = send_q;
    ring_ctrl.op = OP_HOLD;
    ring_ctrl.wr.send_time = now_q;
    ring_ctrl.wr.airtime   = act_air;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        epoch_d      = 1'b1;
        next_cycle_d = nct;
        send_d       = 1'b0;
        if (cycle_due) begin
          slot_tag_d   = tag_q;
          slot_seq_d   = seq_cnt_q;
          seq_cnt_d    = seq_cnt_q + 1'b1;
          slot_due_d   = cyc_start;
          slot_pend_d  = 1'b1;
          next_cycle_d = cyc_start + act_period;
        end
        state_d = ST_GATE;
      end
      ST_GATE: begin
        if (slot_pend_q && reached(now_q, slot_due_q) && !busy_q && !gap_short) begin
          state_d = ST_DROP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DROP: begin
        // Expire one record from the head per cycle.
        if (head_expired) begin
          ring_ctrl.op = OP_SHIFT;
        end else if (ring_full) begin
          state_d = ST_FIN;
        end else begin
          step_d  = '0;
          used_d  = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        // Rotate the occupied cells once round, adding each airtime as it passes the head.
        if (step_q != ring_count) begin
          used_d       = used_q + SUM_W'(head.airtime);
          step_d       = step_q + 1'b1;
          ring_ctrl.op = OP_ROTATE;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        lhs_d   = LHS_W'(LHS_W'(used_q + SUM_W'(act_air)) * LHS_W'(PERMILLE_DIV));
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // Compare against window times permille, which avoids a division by 1000.
        if (CEIL_W'(lhs_q) <= ceil_q) begin
          ring_ctrl.op = OP_CHARGE;
          slot_pend_d  = 1'b0;
          ever_sent_d  = 1'b1;
          last_send_d  = now_q;
          send_d       = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      epoch_q      <= 1'b0;
      next_cycle_q <= '0;
      seq_cnt_q    <= '0;
      slot_tag_q   <= '0;
      slot_seq_q   <= '0;
      slot_due_q   <= '0;
      slot_pend_q  <= 1'b0;
      ever_sent_q  <= 1'b0;
      last_send_q  <= '0;
      send_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      epoch_q      <= epoch_d;
      next_cycle_q <= next_cycle_d;
      seq_cnt_q    <= seq_cnt_d;
      slot_tag_q   <= slot_tag_d;
      slot_seq_q   <= slot_seq_d;
      slot_due_q   <= slot_due_d;
      slot_pend_q  <= slot_pend_d;
      ever_sent_q  <= ever_sent_d;
      last_send_q  <= last_send_d;
      send_q       <= send_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Request capture and walk datapath.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      now_q  <= req_i.now_time;
      busy_q <= req_i.bus_held;
      tag_q  <= req_i.packet_tag;
    end
    step_q <= step_d;
    used_q <= used_d;
    lhs_q  <= lhs_d;
  end

  // Response register: a finished result waits here while the next request is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_send_q <= send_q;
      out_tag_q  <= send_q ? slot_tag_q : '0;
      out_seq_q  <= send_q ? slot_seq_q : '0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.send_now      = out_send_q;
  assign rsp_o.sent_tag      = out_tag_q;
  assign rsp_o.sent_sequence = out_seq_q;

  ptsdl_ring #(
    .N     (RING_ENTRIES),
    .CNT_W (CNT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .head_o  (head),
    .count_o (ring_count),
    .full_o  (ring_full)
  );

  `ASSERT_NEXT(a_req_starts_eval, req_acc, state_q == ST_EVAL, "request did not start evaluation")
  `ASSERT_ALWAYS(a_send_after_charge, (rsp_o.valid && rsp_o.send_now) |-> ever_sent_q, "send reported without a recorded send")
  `ASSERT_ALWAYS(a_idle_fields_zero, (rsp_o.valid && !rsp_o.send_now) |-> (rsp_o.sent_tag == '0 && rsp_o.sent_sequence == '0), "fields set on a tick without send")

endmodule
